FILE: src/mrfe_pkg.sv
`default_nettype none

package mrfe_pkg;

  // buffer geometry
  localparam int BUF_DEPTH = 256;
  localparam int ADDR_W    = $clog2(BUF_DEPTH);
  localparam int CNT_W     = $clog2(BUF_DEPTH + 1);

  // field widths fixed by the frame format
  localparam int LEN_W = 9;
  localparam int LEN_MAX = 511;

  // crc-16, reflected polynomial
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  localparam logic [7:0] GAP_RESET = 8'd6;
  localparam logic [7:0] READ_FILL = 8'hFF;

  // input opcodes
  typedef enum logic [2:0] {
    OP_RX   = 3'd0,
    OP_TICK = 3'd1,
    OP_TXC  = 3'd2,
    OP_TX   = 3'd3,
    OP_READ = 3'd4
  } op_t;

  // result kinds
  localparam logic [1:0] KIND_TICK = 2'd0;
  localparam logic [1:0] KIND_READ = 2'd1;
  localparam logic [1:0] KIND_TX   = 2'd2;

  // frame status codes
  localparam logic [1:0] ST_NONE = 2'd0;
  localparam logic [1:0] ST_GOOD = 2'd1;
  localparam logic [1:0] ST_BAD  = 2'd2;

  typedef struct packed {
    logic [2:0] opcode;
    logic [7:0] data;
    logic [7:0] index;
    logic       last;
  } in_t;

  typedef struct packed {
    logic [1:0]       kind;
    logic [1:0]       status;
    logic [LEN_W-1:0] length;
    logic [7:0]       byte_out;
    logic             end_of_run;
  } out_t;

  // decoded entry held between front and back
  typedef struct packed {
    op_t        op;
    logic [7:0] data;
    logic [7:0] index;
    logic       last;
  } q_item_t;

  typedef struct packed {
    logic    valid;
    q_item_t item;
  } q_head_t;

  // one byte through the crc register, lsb first
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

FILE: src/mrfe_ram.sv
`default_nettype none

module mrfe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // registered read, old data on a same-address write
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

endmodule

`default_nettype wire

FILE: src/mrfe_front.sv
`default_nettype none

module mrfe_front (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire mrfe_pkg::in_t    in_item,
  output mrfe_pkg::q_head_t     head,
  input  wire logic             pop
);

  import mrfe_pkg::*;

  q_item_t    slot [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       accept;
  logic       known;
  logic       push;
  logic       do_pop;
  q_item_t    dec;

  assign in_ready = (count != 2'd2);
  assign accept   = in_valid && in_ready;

  // classify: unknown opcodes are taken and dropped here
  assign known    = (in_item.opcode <= 3'(OP_READ));
  assign push     = accept && known;
  assign do_pop   = pop && (count != 2'd0);

  always_comb begin
    dec.op    = op_t'(in_item.opcode);
    dec.data  = in_item.data;
    dec.index = in_item.index;
    dec.last  = in_item.last;
  end

  // two-entry queue towards the back end
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      unique case ({push, do_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= dec;
    end
  end

  assign head.valid = (count != 2'd0);
  assign head.item  = slot[rd_ptr];

endmodule

`default_nettype wire

FILE: src/mrfe_exec.sv
`default_nettype none

module mrfe_exec (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire mrfe_pkg::q_head_t head,
  output logic                   pop,
  input  wire logic              cfg_we,
  input  wire logic [7:0]        cfg_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output mrfe_pkg::out_t         out_item
);

  import mrfe_pkg::*;

  // transmit sequencing: payload byte, then crc low, then crc high
  typedef enum logic [1:0] {
    PH_DATA,
    PH_LOW,
    PH_HIGH
  } tx_phase_t;

  // architectural state
  logic [CNT_W-1:0] rx_count, rx_count_next;
  logic             timer_running, timer_running_next;
  logic [7:0]       gap_count, gap_count_next;
  logic [15:0]      rx_crc, rx_crc_next;
  logic [15:0]      tx_crc, tx_crc_next;
  tx_phase_t        tx_phase, tx_phase_next;
  logic [7:0]       gap_ticks;

  // result stage and output register
  logic  p_valid;
  out_t  p_item;
  logic  p_read;
  logic  p_in_range;
  logic  p_free;
  logic  o_load;
  logic  x_fire;
  out_t  o_item;

  out_t  res;
  logic  res_valid;
  logic  res_read;
  logic  res_in_range;

  // buffer port
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [7:0]        ram_wdata;
  logic              ram_re;
  logic [ADDR_W-1:0] ram_raddr;
  logic [7:0]        ram_rdata;

  q_item_t it;
  logic    idx_ok;

  assign it     = head.item;
  assign o_load = p_valid && (!out_valid || out_ready);
  assign p_free = !p_valid || o_load;
  assign x_fire = head.valid && p_free;
  assign idx_ok = (32'(it.index) < BUF_DEPTH);

  mrfe_ram #(
    .WIDTH (8),
    .DEPTH (BUF_DEPTH)
  ) u_buf (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // execute the head transaction
  always_comb begin
    rx_count_next      = rx_count;
    timer_running_next = timer_running;
    gap_count_next     = gap_count;
    rx_crc_next        = rx_crc;
    tx_crc_next        = tx_crc;
    tx_phase_next      = tx_phase;
    ram_we             = 1'b0;
    ram_waddr          = '0;
    ram_wdata          = '0;
    ram_re             = 1'b0;
    ram_raddr          = '0;
    res                = '0;
    res_valid          = 1'b0;
    res_read           = 1'b0;
    res_in_range       = 1'b0;
    pop                = 1'b0;
    if (x_fire) begin
      unique case (it.op)
        OP_RX: begin
          pop                = 1'b1;
          gap_count_next     = '0;
          timer_running_next = 1'b1;
          if (rx_count < CNT_W'(BUF_DEPTH)) begin
            ram_we        = 1'b1;
            ram_waddr     = rx_count[ADDR_W-1:0];
            ram_wdata     = it.data;
            rx_count_next = rx_count + CNT_W'(1);
            rx_crc_next   = crc_byte(rx_crc, it.data);
          end else begin
            // overflow: drop the byte and restart reception
            rx_count_next      = '0;
            timer_running_next = 1'b0;
            rx_crc_next        = CRC_INIT;
          end
        end
        OP_TICK: begin
          pop       = 1'b1;
          res_valid = 1'b1;
          res.kind  = KIND_TICK;
          if (timer_running) begin
            if (gap_count >= gap_ticks) begin
              // gap reached: close the frame
              res.status         = (rx_crc == 16'h0000) ? ST_GOOD : ST_BAD;
              res.length         = (32'(rx_count) > LEN_MAX) ? LEN_W'(LEN_MAX)
                                                             : LEN_W'(rx_count);
              rx_count_next      = '0;
              gap_count_next     = '0;
              timer_running_next = 1'b0;
              rx_crc_next        = CRC_INIT;
            end else begin
              gap_count_next = gap_count + 8'd1;
            end
          end else begin
            gap_count_next = '0;
          end
        end
        OP_TXC: begin
          pop                = 1'b1;
          rx_count_next      = '0;
          gap_count_next     = '0;
          timer_running_next = 1'b0;
          rx_crc_next        = CRC_INIT;
        end
        OP_TX: begin
          res_valid = 1'b1;
          res.kind  = KIND_TX;
          unique case (tx_phase)
            PH_DATA: begin
              res.byte_out = it.data;
              tx_crc_next  = crc_byte(tx_crc, it.data);
              if (it.last) begin
                tx_phase_next = PH_LOW;
              end else begin
                pop = 1'b1;
              end
            end
            PH_LOW: begin
              res.byte_out  = tx_crc[7:0];
              tx_phase_next = PH_HIGH;
            end
            PH_HIGH: begin
              res.byte_out   = tx_crc[15:8];
              res.end_of_run = 1'b1;
              tx_crc_next    = CRC_INIT;
              tx_phase_next  = PH_DATA;
              pop            = 1'b1;
            end
            default: begin
              tx_phase_next = PH_DATA;
            end
          endcase
        end
        OP_READ: begin
          pop          = 1'b1;
          res_valid    = 1'b1;
          res.kind     = KIND_READ;
          res_read     = 1'b1;
          res_in_range = idx_ok;
          if (idx_ok) begin
            // read old value, leave the fill byte behind
            ram_re    = 1'b1;
            ram_raddr = ADDR_W'(it.index);
            ram_we    = 1'b1;
            ram_waddr = ADDR_W'(it.index);
            ram_wdata = READ_FILL;
          end
        end
        default: begin
          pop = 1'b1;
        end
      endcase
    end
  end

  // read data joins the result on its way to the output register
  always_comb begin
    o_item = p_item;
    if (p_read) begin
      o_item.byte_out = p_in_range ? ram_rdata : 8'h00;
    end
  end

  // state, result stage and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rx_count      <= '0;
      timer_running <= 1'b0;
      gap_count     <= '0;
      rx_crc        <= CRC_INIT;
      tx_crc        <= CRC_INIT;
      tx_phase      <= PH_DATA;
      gap_ticks     <= GAP_RESET;
      p_valid       <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      rx_count      <= rx_count_next;
      timer_running <= timer_running_next;
      gap_count     <= gap_count_next;
      rx_crc        <= rx_crc_next;
      tx_crc        <= tx_crc_next;
      tx_phase      <= tx_phase_next;
      if (cfg_we) begin
        gap_ticks <= cfg_data;
      end
      if (p_free) begin
        p_valid <= res_valid;
      end
      if (o_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (p_free && res_valid) begin
      p_item     <= res;
      p_read     <= res_read;
      p_in_range <= res_in_range;
    end
    if (o_load) begin
      out_item <= o_item;
    end
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    rx_count <= CNT_W'(BUF_DEPTH))
    else $error("receive count beyond buffer depth");

  a_idle_timer: assert property (@(posedge clk) disable iff (rst)
    !timer_running |-> gap_count == 8'd0)
    else $error("silence counted with timer stopped");

  a_crc_phase: assert property (@(posedge clk) disable iff (rst)
    tx_phase != PH_DATA |-> head.valid && head.item.op == OP_TX && head.item.last)
    else $error("crc append without a final transmit byte at the head");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    p_valid && !p_free |-> !ram_we ##1 p_valid)
    else $error("result stage lost or buffer touched while stalled");
`endif

endmodule

`default_nettype wire

FILE: src/modbus_rtu_frame_engine.sv
// a result passes the result stage and then the output register after its transaction is taken
// throughput: one transaction per cycle while the output is not stalled; the back end emits one
//   result a cycle, so a final transmit byte holds the queue head for byte, crc low and crc high
// reset: synchronous, active high; clears counts, timer, both crcs and gap_ticks (to 6)
// the frame buffer is a ram with no reset and no clearing pass
`default_nettype none

module modbus_rtu_frame_engine (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire mrfe_pkg::in_t  in_item,
  output logic                out_valid,
  input  wire logic           out_ready,
  output mrfe_pkg::out_t      out_item,
  input  wire logic           cfg_we,
  input  wire logic [7:0]     cfg_data
);

  import mrfe_pkg::*;

  q_head_t head;
  logic    pop;

  // accept and classify, queue two deep
  mrfe_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .head     (head),
    .pop      (pop)
  );

  // execute against receive/transmit state and the frame buffer
  mrfe_exec u_exec (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .pop       (pop),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule

`default_nettype wire
